// File: hw/rtl/host_dsp_mailbox_defines.svh
// Assertion macros shared by the mailbox RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef HOST_DSP_MAILBOX_DEFINES_SVH
`define HOST_DSP_MAILBOX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HDM_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("mailbox check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define HDM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("mailbox check failed: next-cycle implication");

`endif

// File: hw/rtl/hdm_pkg.sv
// Types and constants for the host/DSP mailbox.
// No dependencies; imported by hdm_core and host_dsp_mailbox.
package hdm_pkg;

    localparam int DATA_W = 16;
    localparam int REQ_W  = 4;

    // Request codes carried in req_type
    typedef enum logic [REQ_W-1:0] {
        REQ_HOST_CMD_WRITE  = 4'd0,
        REQ_HOST_REPLY_READ = 4'd1,
        REQ_HOST_CTL_READ   = 4'd2,
        REQ_HOST_CTL_WRITE  = 4'd3,
        REQ_DSP_CMD_READ    = 4'd4,
        REQ_DSP_REPLY_WRITE = 4'd5,
        REQ_DSP_STATUS_READ = 4'd6,
        REQ_DSP_ACK         = 4'd7,
        REQ_RESET_LINE      = 4'd8
    } req_e;

    // DSP status byte bits
    localparam logic [DATA_W-1:0] STAT_CMD_FULL   = 16'h0080;
    localparam logic [DATA_W-1:0] STAT_REPLY_FREE = 16'h0040;

    // Bit positions in the DSP flag input byte (0x08 and 0x80)
    localparam int FLAG_CMD_BIT   = 3;
    localparam int FLAG_REPLY_BIT = 7;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] write_data;
        logic              reset_level;
    } hdm_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_buffer_empty;
        logic              irq_data_ready;
        logic              dsp_cmd_flag;
        logic              dsp_reply_flag;
        logic              dsp_irq_line;
        logic              dsp_reset_line;
    } hdm_result_t;

endpackage

// File: hw/rtl/host_dsp_mailbox.sv
// A beat is captured in the input register, applied by hdm_core, and its result is held in the result register.
// Throughput: one beat per cycle; busy stays low, the input register feeds the state update.
// Each beat sees the state left by the previous beat through the registered state update loop in hdm_core.
// Reset: async active low; latches, flags, control and IRQ clear, DSP reset line goes high.
// The receiver cannot stall; done pulses for one cycle per result.
// Top level of the host/DSP mailbox; depends on hdm_pkg and hdm_core.
module host_dsp_mailbox
    import hdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  hdm_req_t    req,
    output logic        done,
    output hdm_result_t result
);

    logic        valid_reg;
    hdm_req_t    req_reg;
    logic        done_reg;
    hdm_result_t result_reg;
    hdm_result_t result_next;

    assign busy = 1'b0;

    // Capture the incoming beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    hdm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (valid_reg),
        .req         (req_reg),
        .result_next (result_next)
    );

    // Register the result beat and its strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hw/rtl/hdm_core.sv
// Mailbox state (latches, full flags, control, DSP lines) and per-beat update.
// Depends on hdm_pkg and host_dsp_mailbox_defines.svh.
`include "host_dsp_mailbox_defines.svh"

module hdm_core
    import hdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  hdm_req_t    req,
    output hdm_result_t result_next
);

    logic [DATA_W-1:0] cmd_latch_reg,   cmd_latch_next;
    logic [DATA_W-1:0] reply_latch_reg, reply_latch_next;
    logic [DATA_W-1:0] control_reg,     control_next;
    logic              cmd_full_reg,    cmd_full_next;
    logic              reply_full_reg,  reply_full_next;
    logic              irq_reg,         irq_next;
    logic              dsp_rst_reg,     dsp_rst_next;
    logic [DATA_W-1:0] rd_data;
    logic [7:0]        flags;
    req_e              code;

    assign code = req_e'(req.req_type);

    // Apply one beat to the state and form its result from the state after it
    always_comb
    begin
        cmd_latch_next   = cmd_latch_reg;
        reply_latch_next = reply_latch_reg;
        control_next     = control_reg;
        cmd_full_next    = cmd_full_reg;
        reply_full_next  = reply_full_reg;
        irq_next         = irq_reg;
        dsp_rst_next     = dsp_rst_reg;
        rd_data          = '0;
        if (req_valid)
        begin
            case (code)
                REQ_HOST_CMD_WRITE:
                begin
                    cmd_latch_next = req.write_data;
                    cmd_full_next  = 1'b1;
                    irq_next       = 1'b1;
                end
                REQ_HOST_REPLY_READ:
                begin
                    reply_full_next = 1'b0;
                    rd_data         = reply_latch_reg;
                end
                REQ_HOST_CTL_READ:
                begin
                    rd_data = {{(DATA_W-2){1'b0}}, cmd_full_reg, reply_full_reg};
                end
                REQ_HOST_CTL_WRITE:
                begin
                    control_next = req.write_data;
                    if (req.write_data[1:0] == 2'b00)
                    begin
                        dsp_rst_next    = 1'b1;
                        cmd_full_next   = 1'b0;
                        reply_full_next = 1'b0;
                    end
                    else
                    begin
                        dsp_rst_next = 1'b0;
                    end
                end
                REQ_DSP_CMD_READ:
                begin
                    cmd_full_next = 1'b0;
                    irq_next      = 1'b0;
                    rd_data       = cmd_latch_reg;
                end
                REQ_DSP_REPLY_WRITE:
                begin
                    reply_latch_next = req.write_data;
                    reply_full_next  = 1'b1;
                end
                REQ_DSP_STATUS_READ:
                begin
                    rd_data = (cmd_full_reg ? STAT_CMD_FULL : '0)
                            | (reply_full_reg ? '0 : STAT_REPLY_FREE);
                end
                REQ_RESET_LINE:
                begin
                    // Driving the line high acts as a control write of zero
                    if (req.reset_level)
                    begin
                        control_next    = '0;
                        cmd_full_next   = 1'b0;
                        reply_full_next = 1'b0;
                    end
                    dsp_rst_next = req.reset_level;
                end
                default:
                begin
                    rd_data = '0;
                end
            endcase
        end

        flags                            = '0;
        flags[FLAG_CMD_BIT]              = cmd_full_next;
        flags[FLAG_REPLY_BIT]            = reply_full_next;

        result_next.read_data        = rd_data;
        result_next.irq_buffer_empty = (control_next[1:0] == 2'b11) && !cmd_full_next;
        result_next.irq_data_ready   = control_next[1] && reply_full_next;
        result_next.dsp_cmd_flag     = flags[FLAG_CMD_BIT];
        result_next.dsp_reply_flag   = flags[FLAG_REPLY_BIT];
        result_next.dsp_irq_line     = irq_next;
        result_next.dsp_reset_line   = dsp_rst_next;
    end

    // Hold mailbox state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_latch_reg   <= '0;
            reply_latch_reg <= '0;
            control_reg     <= '0;
            cmd_full_reg    <= 1'b0;
            reply_full_reg  <= 1'b0;
            irq_reg         <= 1'b0;
            dsp_rst_reg     <= 1'b1;
        end
        else
        begin
            cmd_latch_reg   <= cmd_latch_next;
            reply_latch_reg <= reply_latch_next;
            control_reg     <= control_next;
            cmd_full_reg    <= cmd_full_next;
            reply_full_reg  <= reply_full_next;
            irq_reg         <= irq_next;
            dsp_rst_reg     <= dsp_rst_next;
        end
    end

    `HDM_ASSERT_NEXT(a_cmd_write_sets, clk, rst_n, req_valid && code == REQ_HOST_CMD_WRITE, cmd_full_reg && irq_reg)
    `HDM_ASSERT_NEXT(a_cmd_read_clears, clk, rst_n, req_valid && code == REQ_DSP_CMD_READ, !cmd_full_reg && !irq_reg)
    `HDM_ASSERT_NEXT(a_ctl_zero_resets, clk, rst_n, req_valid && code == REQ_HOST_CTL_WRITE && req.write_data[1:0] == 2'b00, dsp_rst_reg && !cmd_full_reg && !reply_full_reg)
    `HDM_ASSERT_IMP(a_flags_track, clk, rst_n, 1'b1, result_next.dsp_cmd_flag == cmd_full_next && result_next.dsp_reply_flag == reply_full_next)

endmodule
